// ----- hdl/smr_pkg.sv -----
// ----------------------------------------------------------------------------
// smr_pkg
// Shared types, constants and the exponent fraction table for the row softmax.
// ----------------------------------------------------------------------------
`default_nettype none

package smr_pkg;

   // Row geometry
   localparam int ROW_LEN        = 64;
   localparam int ADDR_W         = 6;
   localparam int COUNT_W        = 7;
   localparam int EXP_TABLE_BITS = 8;
   localparam int TAB_SIZE       = 1 << EXP_TABLE_BITS;

   // Arithmetic widths
   localparam int LOGIT_W = 16;
   localparam int EXP_W   = 17;   // Q1.16, at most 1.0
   localparam int SUM_W   = 23;
   localparam int PROD_W  = 33;   // Q8.24 scaled difference
   localparam int INV_W   = 33;   // floor(2^48 / sum), sum >= 2^16
   localparam int MUL_W   = EXP_W + INV_W;
   localparam int PROB_W  = 16;

   // log2(e) in Q.16
   localparam logic [EXP_W-1:0] LOG2E_Q16 = 17'd94548;
   // exponent flushes to zero at this shift
   localparam int EXP_FLUSH_SHIFT = 17;

   typedef struct packed {
      logic signed [LOGIT_W-1:0] logit;
      logic                      last_in_row;
   } req_type;

   typedef struct packed {
      logic [PROB_W-1:0] probability;
      logic [ADDR_W-1:0] position;
      logic              last_of_row;
      logic              row_overflow;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic              load;       // input transaction accepted
      logic              exp_rd;     // read logit at idx
      logic              exp_mul;    // scale difference by log2(e)
      logic              exp_acc;    // form exponent, store, accumulate
      logic              div_start;  // start reciprocal
      logic              nrm_rd;     // read exponent at idx
      logic              nrm_mul;    // exponent times reciprocal
      logic              out_load;   // fill result register
      logic              last_elem;  // idx is the final element of the row
      logic              clear_row;  // return row state to reset values
      logic [ADDR_W-1:0] idx;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               overflow;
      logic               div_done;
      logic               out_free;
   } sts_type;

   typedef logic [EXP_W-1:0] pow_tab_type [TAB_SIZE];

   // floor(sqrt(n)), bit by bit
   function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] bit_v;
      n     = n_in;
      res   = '0;
      bit_v = 64'h4000_0000_0000_0000;
      for (int s = 0; s < 32; s++) begin
         if (bit_v > n) bit_v = bit_v >> 2;
      end
      for (int s = 0; s < 32; s++) begin
         if (bit_v != 0) begin
            if (n >= res + bit_v) begin
               n   = n - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return res;
   endfunction

   // table[j] = 2^(-j / TAB_SIZE) in Q1.16
   function automatic pow_tab_type build_pow_tab();
      pow_tab_type t;
      logic [63:0] roots [EXP_TABLE_BITS];
      logic [63:0] v;
      logic [63:0] acc;
      v = 64'd1 << 29;
      for (int s = EXP_TABLE_BITS - 1; s >= 0; s--) begin
         v        = isqrt64(v << 30);
         roots[s] = v;
      end
      for (int j = 0; j < TAB_SIZE; j++) begin
         acc = 64'd1 << 30;
         for (int b = 0; b < EXP_TABLE_BITS; b++) begin
            if (((j >> b) & 1) != 0) acc = (acc * roots[b]) >> 30;
         end
         t[j] = EXP_W'((acc + (64'd1 << 13)) >> 14);
      end
      return t;
   endfunction

   localparam pow_tab_type POW_TAB = build_pow_tab();

endpackage

`default_nettype wire

// ----- hdl/softmax_row_core.sv -----
// ----------------------------------------------------------------------------
// softmax_row_core
// Row softmax over signed Q8.8 logits, one unsigned Q0.16 result per element.
// ----------------------------------------------------------------------------
//  channel   dir   handshake              payload
//  req_      in    req_valid/req_ready    req_data  (logit, last_in_row)
//  rsp_      out   rsp_valid/rsp_ready    rsp_data  (probability, position,
//                                                    last_of_row, row_overflow)
//
//  Load takes one transaction per cycle. After the last element of a row of
//  n stored elements, the exponent pass visits each element in turn (store
//  read, multiply, table and accumulate), the bit-serial reciprocal follows,
//  and the normalize pass visits each element in turn (store read, multiply,
//  result register).
//  req_ready is low from the end of a row until its last result is loaded.
//  A stalled rsp_ready holds the normalize pass at the result register.
//  Synchronous reset returns the block to load with an empty row.
// ----------------------------------------------------------------------------
`default_nettype none

module softmax_row_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire smr_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output smr_pkg::rsp_type       rsp_data
);

   smr_pkg::cmd_type cmd;
   smr_pkg::sts_type sts;

   // sequencer
   smr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // stores and arithmetic
   smr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- hdl/smr_div.sv -----
// ----------------------------------------------------------------------------
// smr_div
// Restoring divider, one quotient bit per cycle: floor(2^48 / divisor).
// ----------------------------------------------------------------------------
`default_nettype none

module smr_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [smr_pkg::SUM_W-1:0]    divisor,
   output logic                              done,
   output logic      [smr_pkg::INV_W-1:0]    quotient
);

   localparam int STEPS  = 49;   // dividend bits 48 down to 0
   localparam int CNT_W  = 6;
   localparam int REM_W  = smr_pkg::SUM_W + 1;

   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [smr_pkg::INV_W-1:0] q_ff, q_in;
   logic [REM_W:0]            shifted;
   logic                      dbit;
   logic                      fits;

   // only the leading dividend bit is set
   assign dbit    = (cnt_ff == CNT_W'(STEPS));
   assign shifted = {rem_ff, dbit};
   assign fits    = shifted >= (REM_W+1)'(divisor);

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (start) begin
         cnt_in  = CNT_W'(STEPS);
         busy_in = 1'b1;
         rem_in  = '0;
         q_in    = '0;
      end else if (busy_ff) begin
         rem_in = fits ? REM_W'(shifted - (REM_W+1)'(divisor)) : REM_W'(shifted);
         q_in   = {q_ff[smr_pkg::INV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

// ----- hdl/smr_datapath.sv -----
// ----------------------------------------------------------------------------
// smr_datapath
// Row stores, running maximum, exponent unit, sum, reciprocal and result
// register of the row softmax.
// ----------------------------------------------------------------------------
`default_nettype none

module smr_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire smr_pkg::req_type  req_data,
   input  wire smr_pkg::cmd_type  cmd,
   output smr_pkg::sts_type       sts,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output smr_pkg::rsp_type       rsp_data
);

   localparam int QTOP_W = smr_pkg::MUL_W + 1 - 32;

   // row state
   logic signed [smr_pkg::LOGIT_W-1:0] max_ff;
   logic [smr_pkg::COUNT_W-1:0]        count_ff;
   logic                               ovf_ff;
   logic [smr_pkg::SUM_W-1:0]          sum_ff;

   // memories
   logic [smr_pkg::LOGIT_W-1:0] row_mem [smr_pkg::ROW_LEN];
   logic [smr_pkg::EXP_W-1:0]   exp_mem [smr_pkg::ROW_LEN];

   // pipeline registers
   logic [smr_pkg::LOGIT_W-1:0] rd_row_ff;
   logic [smr_pkg::EXP_W-1:0]   rd_exp_ff;
   logic [smr_pkg::PROD_W-1:0]  prod_ff;
   logic [smr_pkg::MUL_W-1:0]   mul_ff;
   logic                        rsp_valid_ff;
   smr_pkg::rsp_type            rsp_ff;

   logic                                 room;
   logic [smr_pkg::LOGIT_W-1:0]          diff;
   logic [8:0]                           k;
   logic [smr_pkg::EXP_TABLE_BITS-1:0]   j;
   logic [smr_pkg::EXP_W-1:0]            e_val;
   logic [smr_pkg::MUL_W:0]              rounded;
   logic [QTOP_W-1:0]                    q_top;
   logic [smr_pkg::PROB_W-1:0]           prob;
   logic                                 div_done;
   logic [smr_pkg::INV_W-1:0]            inv;

   assign room = count_ff < smr_pkg::COUNT_W'(smr_pkg::ROW_LEN);

   // row state: max, count, overflow, sum
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_row) begin
         max_ff   <= {1'b1, {(smr_pkg::LOGIT_W-1){1'b0}}};
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         sum_ff   <= '0;
      end else begin
         if (cmd.load) begin
            if (room) begin
               if (req_data.logit > max_ff) max_ff <= req_data.logit;
               count_ff <= count_ff + 1'b1;
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (cmd.exp_acc) sum_ff <= sum_ff + smr_pkg::SUM_W'(e_val);
      end
   end

   // stores, written and read with registered read data
   always_ff @(posedge clock) begin
      if (cmd.load && room) row_mem[count_ff[smr_pkg::ADDR_W-1:0]] <= req_data.logit;
      if (cmd.exp_rd) rd_row_ff <= row_mem[cmd.idx];
      if (cmd.exp_acc) exp_mem[cmd.idx] <= e_val;
      if (cmd.nrm_rd) rd_exp_ff <= exp_mem[cmd.idx];
   end

   // exponent: difference times log2(e), then table and shift
   assign diff  = max_ff - rd_row_ff;
   assign k     = prod_ff[smr_pkg::PROD_W-1:24];
   assign j     = prod_ff[23 -: smr_pkg::EXP_TABLE_BITS];
   assign e_val = (k >= 9'(smr_pkg::EXP_FLUSH_SHIFT)) ? '0
                : (smr_pkg::POW_TAB[j] >> k[4:0]);

   always_ff @(posedge clock) begin
      if (cmd.exp_mul)
         prod_ff <= smr_pkg::PROD_W'(diff) * smr_pkg::PROD_W'(smr_pkg::LOG2E_Q16);
      if (cmd.nrm_mul)
         mul_ff <= smr_pkg::MUL_W'(rd_exp_ff) * smr_pkg::MUL_W'(inv);
   end

   // reciprocal of the sum
   smr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (sum_ff),
      .done     (div_done),
      .quotient (inv)
   );

   // round to Q0.16 and saturate
   assign rounded = (smr_pkg::MUL_W+1)'(mul_ff) + ((smr_pkg::MUL_W+1)'(1) << 31);
   assign q_top   = rounded[smr_pkg::MUL_W:32];
   assign prob    = (q_top > QTOP_W'(16'hFFFF)) ? 16'hFFFF : q_top[smr_pkg::PROB_W-1:0];

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.probability  <= prob;
         rsp_ff.position     <= cmd.idx;
         rsp_ff.last_of_row  <= cmd.last_elem;
         rsp_ff.row_overflow <= ovf_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;
   assign sts.count    = count_ff;
   assign sts.overflow = ovf_ff;
   assign sts.div_done = div_done;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

// ----- hdl/smr_ctrl.sv -----
// ----------------------------------------------------------------------------
// smr_ctrl
// Sequencer for load, exponent pass, reciprocal and normalize pass.
// ----------------------------------------------------------------------------
`default_nettype none

module smr_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire smr_pkg::req_type  req_data,
   output logic                   req_ready,
   input  wire smr_pkg::sts_type  sts,
   output smr_pkg::cmd_type       cmd
);

   localparam logic [3:0] S_LOAD     = 4'd0;
   localparam logic [3:0] S_EXP_RD   = 4'd1;
   localparam logic [3:0] S_EXP_MUL  = 4'd2;
   localparam logic [3:0] S_EXP_ACC  = 4'd3;
   localparam logic [3:0] S_DIV_GO   = 4'd4;
   localparam logic [3:0] S_DIV_WAIT = 4'd5;
   localparam logic [3:0] S_NRM_RD   = 4'd6;
   localparam logic [3:0] S_NRM_MUL  = 4'd7;
   localparam logic [3:0] S_NRM_OUT  = 4'd8;

   logic [3:0]                  state_ff, state_in;
   logic [smr_pkg::COUNT_W-1:0] idx_ff, idx_in;
   logic [smr_pkg::COUNT_W-1:0] idx_next;
   logic                        at_end;

   assign idx_next = idx_ff + 1'b1;
   assign at_end   = (idx_next == sts.count);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cmd       = '0;
      cmd.idx   = idx_ff[smr_pkg::ADDR_W-1:0];
      cmd.last_elem = at_end;
      req_ready = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid && req_data.last_in_row) begin
               state_in = S_EXP_RD;
               idx_in   = '0;
            end
         end
         S_EXP_RD: begin
            cmd.exp_rd = 1'b1;
            state_in   = S_EXP_MUL;
         end
         S_EXP_MUL: begin
            cmd.exp_mul = 1'b1;
            state_in    = S_EXP_ACC;
         end
         S_EXP_ACC: begin
            cmd.exp_acc = 1'b1;
            idx_in      = idx_next;
            state_in    = at_end ? S_DIV_GO : S_EXP_RD;
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (sts.div_done) begin
               state_in = S_NRM_RD;
               idx_in   = '0;
            end
         end
         S_NRM_RD: begin
            cmd.nrm_rd = 1'b1;
            state_in   = S_NRM_MUL;
         end
         S_NRM_MUL: begin
            cmd.nrm_mul = 1'b1;
            state_in    = S_NRM_OUT;
         end
         S_NRM_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               idx_in       = idx_next;
               if (at_end) begin
                  cmd.clear_row = 1'b1;
                  state_in      = S_LOAD;
               end else begin
                  state_in = S_NRM_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // result register is never overwritten while still held
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result loaded while register busy");

   // stored count never exceeds the row store
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      sts.count <= smr_pkg::COUNT_W'(smr_pkg::ROW_LEN))
      else $error("element count beyond row length");

   // drops only happen with a full row
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      sts.overflow |-> (sts.count == smr_pkg::COUNT_W'(smr_pkg::ROW_LEN)))
      else $error("overflow flagged on a partial row");

   // the passes never run on an empty row
   a_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.exp_rd || cmd.nrm_rd) |-> (sts.count != '0))
      else $error("pass started on empty row");

endmodule

`default_nettype wire
